### hw/rtl/slr_pkg.sv
package slr_pkg;

    localparam int BYTE_W = 8;
    localparam int CRC_W = 16;
    localparam int LEN_W = 16;
    localparam int CNT_W = LEN_W + 1;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] MARK_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] VERSION_BYTE = 8'h01;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT_RESET = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_FF    = 3'd1,
        PH_SYNC2 = 3'd2,
        PH_VER   = 3'd3,
        PH_LENH  = 3'd4,
        PH_LENL  = 3'd5,
        PH_BODY  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        EV_DATA = 2'd0,
        EV_DONE = 2'd1,
        EV_ERR  = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        ERR_SYNC    = 2'd0,
        ERR_VERSION = 2'd1,
        ERR_ZERO    = 2'd2
    } t_err;

    typedef struct packed {
        logic [1:0]        event_res;
        logic [BYTE_W-1:0] payload_byte;
        logic              crc_ok;
        logic [1:0]        error_code;
    } t_result;

    // One byte of CRC-16-CCITT, MSB first, eight bit steps unrolled.
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### hw/rtl/slr_stream_if.sv
interface slr_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/sync_length_crc_frame_receiver_unit.sv
// Length-prefixed frame receiver with a CRC-16-CCITT check.
// Bytes arrive one per transfer on i_rx (valid/ready, payload is the byte).
// The receiver hunts for 0x55 0xFF 0x55, checks version 0x01, reads a
// big-endian 16-bit length, forwards each payload byte as a data result,
// and after the big-endian CRC gives a frame-done result carrying crc_ok.
// Header mismatches and a zero length give a framing-error result.
// Results leave on o_res as a t_result struct, at most one per input byte.
// The CRC start value is written through i_cfg_we / i_cfg_data; the user must
// write it only while the block is idle, which the block itself does not
// enforce. A write takes effect when the next length field ends. Each input
// byte passes through the input register, then the framing logic, into the
// result register. Throughput is one byte per cycle while o_res is not
// stalled, set by the combinational CRC byte update and phase logic.
// When o_res is stalled the result register holds, the input register still
// fills once, and then i_rx.ready drops until the result is taken.
// A synchronous active-low reset empties both registers, returns the
// receiver to hunting and sets the CRC start value to 0xFFFF.
module sync_length_crc_frame_receiver_unit
    import slr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    slr_stream_if.sink       i_rx,
    slr_stream_if.source     o_res,
    input  logic             i_cfg_we,
    input  logic [CRC_W-1:0] i_cfg_data
);

    logic [CRC_W-1:0]  r_crc_init;
    logic              adv;
    logic              byte_vld;
    logic [BYTE_W-1:0] byte_q;
    logic              res_vld;
    t_result           res;

    // The CRC start value is a plain register written at any enabled edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_init <= CRC_INIT_RESET;
        end else if (i_cfg_we) begin
            r_crc_init <= i_cfg_data;
        end
    end

    slr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .i_byte  (i_rx.payload),
        .o_ready (i_rx.ready),
        .i_adv   (adv),
        .o_valid (byte_vld),
        .o_byte  (byte_q)
    );

    slr_deframer u_deframer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (byte_vld),
        .i_byte     (byte_q),
        .i_crc_init (r_crc_init),
        .o_adv      (adv),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_rdy  (o_res.ready)
    );

    assign o_res.valid   = res_vld;
    assign o_res.payload = res;

endmodule

### hw/rtl/slr_in_reg.sv
module slr_in_reg
    import slr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_ready,
    input  logic              i_adv,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_vld;
    logic [BYTE_W-1:0] r_byte;

    // The stage frees up whenever the next stage takes its byte.
    assign o_ready = !r_vld || i_adv;
    assign o_valid = r_vld;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

### hw/rtl/slr_deframer.sv
module slr_deframer
    import slr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_vld,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [CRC_W-1:0]  i_crc_init,
    output logic              o_adv,
    output logic              o_res_vld,
    output t_result           o_res,
    input  logic              i_res_rdy
);

    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_crc_hi, n_crc_hi;
    logic              r_res_vld, n_emit;
    t_result           r_res, n_res;
    logic              fire;

    assign o_adv     = !r_res_vld || i_res_rdy;
    assign fire      = i_byte_vld && o_adv;
    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;
        n_emit   = 1'b0;
        n_res    = '0;
        unique case (r_phase)
            PH_SYNC1, PH_FF, PH_SYNC2: begin
                if ((r_phase == PH_FF && i_byte == MARK_BYTE) ||
                    (r_phase != PH_FF && i_byte == SYNC_BYTE)) begin
                    n_phase = t_phase'(r_phase + 3'd1);
                end else begin
                    n_phase = PH_SYNC1;
                    n_len   = '0;
                    n_cnt   = '0;
                    n_emit  = 1'b1;
                    n_res.event_res  = EV_ERR;
                    n_res.error_code = ERR_SYNC;
                end
            end
            PH_VER: begin
                if (i_byte == VERSION_BYTE) begin
                    n_phase = PH_LENH;
                end else begin
                    n_phase = PH_SYNC1;
                    n_len   = '0;
                    n_cnt   = '0;
                    n_emit  = 1'b1;
                    n_res.event_res  = EV_ERR;
                    n_res.error_code = ERR_VERSION;
                end
            end
            PH_LENH: begin
                n_len   = {i_byte, 8'h00};
                n_phase = PH_LENL;
            end
            PH_LENL: begin
                n_len   = {r_len[LEN_W-1:BYTE_W], i_byte};
                n_cnt   = '0;
                n_crc   = i_crc_init;
                n_phase = PH_BODY;
            end
            PH_BODY: begin
                n_cnt = r_cnt + 1'b1;
                if (r_len == '0) begin
                    n_phase = PH_SYNC1;
                    n_cnt   = '0;
                    n_emit  = 1'b1;
                    n_res.event_res  = EV_ERR;
                    n_res.error_code = ERR_ZERO;
                end else if (r_cnt < {1'b0, r_len}) begin
                    // The first payload byte stays out of the CRC.
                    if (r_cnt != '0) begin
                        n_crc = crc16_byte(r_crc, i_byte);
                    end
                    n_emit = 1'b1;
                    n_res.event_res    = EV_DATA;
                    n_res.payload_byte = i_byte;
                end else if (r_cnt == {1'b0, r_len}) begin
                    n_crc_hi = i_byte;
                end else begin
                    n_phase = PH_SYNC1;
                    n_len   = '0;
                    n_cnt   = '0;
                    n_emit  = 1'b1;
                    n_res.event_res = EV_DONE;
                    n_res.crc_ok    = ({r_crc_hi, i_byte} == r_crc);
                end
            end
            default: begin
                n_phase = PH_SYNC1;
                n_len   = '0;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SYNC1;
            r_len     <= '0;
            r_cnt     <= '0;
            r_crc     <= CRC_INIT_RESET;
            r_crc_hi  <= '0;
            r_res_vld <= 1'b0;
        end else begin
            if (fire) begin
                r_phase  <= n_phase;
                r_len    <= n_len;
                r_cnt    <= n_cnt;
                r_crc    <= n_crc;
                r_crc_hi <= n_crc_hi;
            end
            if (o_adv) begin
                r_res_vld <= fire && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

`ifndef SYNTH
    a_back_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_emit && n_res.event_res != EV_DATA) |=> r_phase == PH_SYNC1)
        else $error("phase did not return to hunting after a frame end");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_cnt <= {1'b0, r_len} + 1'b1))
        else $error("byte count ran past the frame");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.event_res != EV_DATA) |-> r_res.payload_byte == '0)
        else $error("payload byte set on a non-data result");

    a_ok_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.crc_ok) |-> r_res.event_res == EV_DONE)
        else $error("crc_ok set outside a frame-done result");
`endif

endmodule
